[sv/env_sensor_compensation_macros.svh]
// Assertion macros shared by the compensation block RTL.
// No dependencies.
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ESC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ESC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/esc_pkg.sv]
// Types and constants for the sensor compensation block.
// No dependencies.
package esc_pkg;

    typedef struct packed {
        logic [15:0] raw_humidity;
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
    } esc_in_t;

    typedef struct packed {
        logic [16:0]        humidity_q22_10;
        logic               pressure_valid;
        logic [31:0]        pressure_q24_8;
        logic signed [31:0] fine_temperature;
    } esc_out_t;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 64;
    localparam logic [CfgIdxW-1:0] REG_TEMP      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_LOW = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_HI  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MIXED     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HUM       = 3'd4;

    localparam int unsigned DivW = 64;

    // Side data carried through the divider: fine temperature, raw humidity,
    // zero-divisor flag.
    localparam int unsigned SideW = 32 + 16 + 1;

    // Operands handed to the divider, with their valid bit.
    typedef struct packed {
        logic              valid;
        logic [DivW-1:0]   num;
        logic [DivW-1:0]   den;
    } esc_div_req_t;

endpackage

[sv/esc_sdiv.sv]
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on esc_pkg. Side data travels with each operand pair.
module esc_sdiv (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  esc_pkg::esc_div_req_t        req,
    input  logic [esc_pkg::SideW-1:0]    side_in,
    output logic                         out_valid,
    output logic [esc_pkg::DivW-1:0]     quot,
    output logic [esc_pkg::SideW-1:0]    side_out
);
    import esc_pkg::*;

    localparam int unsigned N = DivW;

    logic [N:0]       vld_reg;
    logic [N-1:0]     rem_reg  [N+1];
    logic [N-1:0]     q_reg    [N+1];
    logic [N-1:0]     d_reg    [N+1];
    logic             neg_reg  [N+1];
    logic [SideW-1:0] side_reg [N+1];

    logic [N-1:0] an;
    logic [N-1:0] ad;
    assign an = req.num[N-1] ? (N'(0) - req.num) : req.num;
    assign ad = req.den[N-1] ? (N'(0) - req.den) : req.den;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-1:0], req.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            q_reg[0]    <= an;
            d_reg[0]    <= ad;
            neg_reg[0]  <= req.num[N-1] ^ req.den[N-1];
            side_reg[0] <= side_in;
        end
    end

    // Restoring step: shift in the next dividend bit, subtract the divisor if it fits.
    for (genvar s = 0; s < N; s++) begin : g_step
        logic [N:0]   trial;
        logic [N:0]   diff;
        assign trial = {rem_reg[s], q_reg[s][N-1]};
        assign diff  = trial - {1'b0, d_reg[s]};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!diff[N]) begin
                    rem_reg[s+1] <= diff[N-1:0];
                    q_reg[s+1]   <= {q_reg[s][N-2:0], 1'b1};
                end else begin
                    rem_reg[s+1] <= trial[N-1:0];
                    q_reg[s+1]   <= {q_reg[s][N-2:0], 1'b0};
                end
                d_reg[s+1]    <= d_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign quot      = neg_reg[N] ? (N'(0) - q_reg[N]) : q_reg[N];
    assign side_out  = side_reg[N];

endmodule

[sv/env_sensor_compensation.sv]
// Sensor compensation block: temperature, pressure, humidity.
// Channels: s_ takes a raw sample triple (esc_in_t), m_ returns one result
// (esc_out_t) for each transfer, in order. Coefficients are written through
// cfg_we / cfg_index / cfg_wdata; the user must write them only while the
// block is idle, which the block does not enforce; unknown indexes are
// ignored. All coefficient registers reset to zero. A sample passes the
// front multiply stages, the 64-step restoring divider and the back multiply
// stages. Throughput: one sample per cycle unless the receiver stalls. The
// whole pipeline advances when the output register is empty or being taken;
// when the receiver stalls with a full output register every stage holds and
// s_ready drops, so nothing is lost or repeated. Reset clears all valid bits;
// the output holds nothing. The pressure divisor test travels with the
// divider; a zero divisor gives pressure 0 with pressure_valid low.
module env_sensor_compensation (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  esc_pkg::esc_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output esc_pkg::esc_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [esc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [esc_pkg::CfgDataW-1:0]  cfg_wdata
);
    import esc_pkg::*;
    `include "env_sensor_compensation_macros.svh"

    logic [47:0] temp_reg;
    logic [63:0] pl_reg;
    logic [63:0] ph_reg;
    logic [39:0] mix_reg;
    logic [47:0] hum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg <= '0;
            pl_reg   <= '0;
            ph_reg   <= '0;
            mix_reg  <= '0;
            hum_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TEMP:      temp_reg <= cfg_wdata[47:0];
                REG_PRESS_LOW: pl_reg   <= cfg_wdata;
                REG_PRESS_HI:  ph_reg   <= cfg_wdata;
                REG_MIXED:     mix_reg  <= cfg_wdata[39:0];
                REG_HUM:       hum_reg  <= cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    // coefficient views
    logic signed [31:0] t1, t2, t3;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;
    assign t1 = {16'd0, temp_reg[15:0]};
    assign t2 = {{16{temp_reg[31]}}, temp_reg[31:16]};
    assign t3 = {{16{temp_reg[47]}}, temp_reg[47:32]};
    assign p1 = {48'd0, pl_reg[15:0]};
    assign p2 = {{48{pl_reg[31]}}, pl_reg[31:16]};
    assign p3 = {{48{pl_reg[47]}}, pl_reg[47:32]};
    assign p4 = {{48{pl_reg[63]}}, pl_reg[63:48]};
    assign p5 = {{48{ph_reg[15]}}, ph_reg[15:0]};
    assign p6 = {{48{ph_reg[31]}}, ph_reg[31:16]};
    assign p7 = {{48{ph_reg[47]}}, ph_reg[47:32]};
    assign p8 = {{48{ph_reg[63]}}, ph_reg[63:48]};
    assign p9 = {{48{mix_reg[15]}}, mix_reg[15:0]};
    assign h1 = {24'd0, mix_reg[23:16]};
    assign h3 = {24'd0, mix_reg[31:24]};
    assign h6 = {{24{mix_reg[39]}}, mix_reg[39:32]};
    assign h2 = {{16{hum_reg[15]}}, hum_reg[15:0]};
    assign h4 = {{16{hum_reg[31]}}, hum_reg[31:16]};
    assign h5 = {{16{hum_reg[47]}}, hum_reg[47:32]};

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- temperature: T1..T3 ----------------
    logic        v1_reg;
    esc_in_t     d1_reg;
    logic [31:0] ta_reg, tb_reg;
    logic [31:0] a_c, b_c;
    assign a_c = {15'd0, s_data.raw_temperature[19:3]} - {t1[30:0], 1'b0};
    assign b_c = {16'd0, s_data.raw_temperature[19:4]} - t1;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_reg <= s_data;
            ta_reg <= a_c;
            tb_reg <= b_c;
        end
    end

    logic        v2_reg;
    esc_in_t     d2_reg;
    logic signed [31:0] tv1_reg, tbb_reg;
    logic signed [31:0] m_at, m_bb;
    assign m_at = $signed(ta_reg) * t2;
    assign m_bb = $signed(tb_reg) * $signed(tb_reg);
    always_ff @(posedge aclk) begin
        if (adv) begin
            d2_reg  <= d1_reg;
            tv1_reg <= m_at >>> 11;
            tbb_reg <= m_bb >>> 12;
        end
    end

    logic        v3_reg;
    esc_in_t     d3_reg;
    logic signed [31:0] tv1b_reg, tv2m_reg;
    logic signed [31:0] m_t3;
    assign m_t3 = tbb_reg * t3;
    always_ff @(posedge aclk) begin
        if (adv) begin
            d3_reg   <= d2_reg;
            tv1b_reg <= tv1_reg;
            tv2m_reg <= m_t3;
        end
    end

    logic        v4_reg;
    esc_in_t     d4_reg;
    logic signed [31:0] tf_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            d4_reg <= d3_reg;
            tf_reg <= tv1b_reg + (tv2m_reg >>> 14);
        end
    end

    // ---------------- pressure front: w1 terms ----------------
    logic signed [63:0] w1_c;
    assign w1_c = {{32{tf_reg[31]}}, tf_reg} - 64'sd128000;

    logic        v5_reg;
    esc_in_t     d5_reg;
    logic signed [31:0] tf5_reg;
    logic signed [63:0] ww_reg, w1p5_reg, w1p2_reg;
    // w1 fits in 33 bits so these products stay within one multiplier each
    always_ff @(posedge aclk) begin
        if (adv) begin
            d5_reg   <= d4_reg;
            tf5_reg  <= tf_reg;
            ww_reg   <= w1_c * w1_c;
            w1p5_reg <= w1_c * p5;
            w1p2_reg <= w1_c * p2;
        end
    end

    logic        v6_reg;
    esc_in_t     d6_reg;
    logic signed [31:0] tf6_reg;
    logic signed [63:0] wwp6_reg, wwp3_reg, w1p5b_reg, w1p2b_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            d6_reg    <= d5_reg;
            tf6_reg   <= tf5_reg;
            wwp6_reg  <= ww_reg * p6;
            wwp3_reg  <= ww_reg * p3;
            w1p5b_reg <= w1p5_reg;
            w1p2b_reg <= w1p2_reg;
        end
    end

    logic        v7_reg;
    esc_in_t     d7_reg;
    logic signed [31:0] tf7_reg;
    logic signed [63:0] w2_reg, w1s_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            d7_reg  <= d6_reg;
            tf7_reg <= tf6_reg;
            w2_reg  <= wwp6_reg + (w1p5b_reg <<< 17) + (p4 <<< 35);
            w1s_reg <= (wwp3_reg >>> 8) + (w1p2b_reg <<< 12) + (64'sd1 <<< 47);
        end
    end

    logic        v8_reg;
    esc_in_t     d8_reg;
    logic signed [31:0] tf8_reg;
    logic signed [63:0] den_reg, pn_reg;
    logic signed [63:0] pp_c;
    assign pp_c = 64'sd1048576 - $signed({44'd0, d7_reg.raw_pressure});
    always_ff @(posedge aclk) begin
        if (adv) begin
            d8_reg  <= d7_reg;
            tf8_reg <= tf7_reg;
            den_reg <= (w1s_reg * p1) >>> 33;
            pn_reg  <= (pp_c <<< 31) - w2_reg;
        end
    end

    logic        v9_reg;
    esc_in_t     d9_reg;
    logic signed [31:0] tf9_reg;
    logic signed [63:0] den9_reg, num_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            d9_reg   <= d8_reg;
            tf9_reg  <= tf8_reg;
            den9_reg <= den_reg;
            num_reg  <= pn_reg * 64'sd3125;
        end
    end

    // ---------------- pressure divider (raw humidity carried beside it) ----------------
    // carried through the divider: tf, raw humidity, zero-divisor flag
    esc_div_req_t dreq;
    logic         dv_out;
    logic [63:0]  dq;
    logic [SideW-1:0] side_o;
    assign dreq.valid = v9_reg;
    assign dreq.num   = num_reg;
    assign dreq.den   = (den9_reg == 64'sd0) ? 64'd1 : den9_reg;

    esc_sdiv u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .req      (dreq),
        .side_in  ({tf9_reg, d9_reg.raw_humidity, den9_reg == 64'sd0}),
        .out_valid(dv_out),
        .quot     (dq),
        .side_out (side_o)
    );

    logic signed [31:0] tf_d;
    logic [15:0]        rh_d;
    logic               zd_d;
    assign tf_d = side_o[SideW-1 -: 32];
    assign rh_d = side_o[16:1];
    assign zd_d = side_o[0];

    // ---------------- post-divider pressure and humidity ----------------
    logic        va_reg;
    logic signed [31:0] tfa_reg;
    logic        zda_reg;
    logic signed [63:0] pa_reg, p13_reg;
    logic signed [31:0] xa_reg, lefta_reg;
    logic signed [31:0] x_c;
    assign x_c = tf_d - 32'sd76800;
    always_ff @(posedge aclk) begin
        if (adv) begin
            tfa_reg   <= tf_d;
            zda_reg   <= zd_d;
            pa_reg    <= dq;
            p13_reg   <= $signed(dq) >>> 13;
            xa_reg    <= x_c;
            lefta_reg <= ({16'd0, rh_d} <<< 14) - (h4 <<< 20);
        end
    end

    logic        vb_reg;
    logic signed [31:0] tfb_reg;
    logic        zdb_reg;
    logic signed [63:0] pb_reg, p13b_reg, p1313_reg, p8p_reg;
    logic signed [31:0] h5x_reg, in1_reg, in2_reg, leftb_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            tfb_reg   <= tfa_reg;
            zdb_reg   <= zda_reg;
            pb_reg    <= pa_reg;
            p13b_reg  <= p13_reg;
            p1313_reg <= p9 * p13_reg;
            p8p_reg   <= (p8 * pa_reg) >>> 19;
            h5x_reg   <= h5 * xa_reg;
            in1_reg   <= (xa_reg * h6) >>> 10;
            in2_reg   <= ((xa_reg * h3) >>> 11) + 32'sd32768;
            leftb_reg <= lefta_reg;
        end
    end

    // low 64 bits of the square term from three 32-bit partial products
    logic        vc_reg;
    logic signed [31:0] tfc_reg;
    logic        zdc_reg;
    logic signed [63:0] pc_reg, p8c_reg;
    logic [63:0] sqll_reg;
    logic [31:0] sqlh_reg, sqhl_reg;
    logic signed [31:0] leftc_reg, rightc_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            tfc_reg    <= tfb_reg;
            zdc_reg    <= zdb_reg;
            pc_reg     <= pb_reg;
            sqll_reg   <= {32'd0, p1313_reg[31:0]} * {32'd0, p13b_reg[31:0]};
            sqlh_reg   <= p1313_reg[31:0] * p13b_reg[63:32];
            sqhl_reg   <= p1313_reg[63:32] * p13b_reg[31:0];
            p8c_reg    <= p8p_reg;
            leftc_reg  <= (leftb_reg - h5x_reg + 32'sd16384) >>> 15;
            rightc_reg <= ((in1_reg * in2_reg) >>> 10) + 32'sd2097152;
        end
    end

    logic        vd_reg;
    logic signed [31:0] tfd_reg;
    logic        zdd_reg;
    logic signed [63:0] pd_reg, w1d_reg, p8d_reg;
    logic signed [31:0] leftd_reg, rightd_reg;
    logic [63:0] sq_c;
    assign sq_c = sqll_reg + {sqlh_reg + sqhl_reg, 32'd0};
    always_ff @(posedge aclk) begin
        if (adv) begin
            tfd_reg    <= tfc_reg;
            zdd_reg    <= zdc_reg;
            pd_reg     <= pc_reg;
            w1d_reg    <= $signed(sq_c) >>> 25;
            p8d_reg    <= p8c_reg;
            leftd_reg  <= leftc_reg;
            rightd_reg <= ((rightc_reg * h2) + 32'sd8192) >>> 14;
        end
    end

    logic        ve_reg;
    logic signed [31:0] tfe_reg;
    logic        zde_reg;
    logic [31:0] prese_reg;
    logic signed [31:0] xe_reg;
    logic signed [63:0] pfin_c;
    assign pfin_c = ((pd_reg + w1d_reg + p8d_reg) >>> 8) + (p7 <<< 4);
    always_ff @(posedge aclk) begin
        if (adv) begin
            tfe_reg   <= tfd_reg;
            zde_reg   <= zdd_reg;
            prese_reg <= pfin_c[31:0];
            xe_reg    <= leftd_reg * rightd_reg;
        end
    end

    logic        vf_reg;
    logic signed [31:0] tff_reg;
    logic        zdf_reg;
    logic [31:0] presf_reg;
    logic signed [31:0] xf_reg, yyf_reg;
    logic signed [31:0] y_c;
    assign y_c = xe_reg >>> 15;
    always_ff @(posedge aclk) begin
        if (adv) begin
            tff_reg   <= tfe_reg;
            zdf_reg   <= zde_reg;
            presf_reg <= prese_reg;
            xf_reg    <= xe_reg;
            yyf_reg   <= (y_c * y_c) >>> 7;
        end
    end

    logic        vg_reg;
    logic signed [31:0] tfg_reg;
    logic        zdg_reg;
    logic [31:0] presg_reg;
    logic signed [31:0] xg_reg, yhg_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            tfg_reg   <= tff_reg;
            zdg_reg   <= zdf_reg;
            presg_reg <= presf_reg;
            xg_reg    <= xf_reg;
            yhg_reg   <= yyf_reg * h1;
        end
    end

    logic signed [31:0] hx_c;
    logic [31:0]        hcl_c;
    assign hx_c = xg_reg - (yhg_reg >>> 4);
    always_comb begin
        if (hx_c[31]) begin
            hcl_c = '0;
        end else if (hx_c > 32'sd419430400) begin
            hcl_c = 32'd419430400;
        end else begin
            hcl_c = hx_c;
        end
    end

    esc_out_t out_next;
    esc_out_t m_data_reg;
    logic     m_valid_reg;
    always_comb begin
        out_next.fine_temperature = tfg_reg;
        out_next.pressure_q24_8   = zdg_reg ? 32'd0 : presg_reg;
        out_next.pressure_valid   = !zdg_reg;
        out_next.humidity_q22_10  = hcl_c[28:12];
    end

    // valid bits for every stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            v9_reg <= 1'b0; va_reg <= 1'b0; vb_reg <= 1'b0; vc_reg <= 1'b0;
            vd_reg <= 1'b0; ve_reg <= 1'b0; vf_reg <= 1'b0; vg_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid; v2_reg <= v1_reg; v3_reg <= v2_reg;
            v4_reg <= v3_reg; v5_reg <= v4_reg; v6_reg <= v5_reg;
            v7_reg <= v6_reg; v8_reg <= v7_reg; v9_reg <= v8_reg;
            va_reg <= dv_out; vb_reg <= va_reg; vc_reg <= vb_reg;
            vd_reg <= vc_reg; ve_reg <= vd_reg; vf_reg <= ve_reg;
            vg_reg <= vf_reg; m_valid_reg <= vg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ESC_ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result changed while stalled")
    `ESC_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_valid, s_ready,
        "input blocked with empty output")
    `ESC_ASSERT_IMPL(a_press_flag, aclk, aresetn, m_valid && !m_data.pressure_valid,
        m_data.pressure_q24_8 == 32'd0, "invalid pressure not zero")
    `ESC_ASSERT_IMPL(a_hum_range, aclk, aresetn, m_valid,
        m_data.humidity_q22_10 <= 17'd102400, "humidity out of range")

endmodule

[sim/testbench.sv]
// Self-checking bench for env_sensor_compensation: random and directed sample triples
// over several coefficient sets, checked against an integer compensation predictor.
// Depends on esc_pkg and the env_sensor_compensation RTL.
`timescale 1ns / 1ps

module testbench;
    import esc_pkg::*;

    localparam int unsigned CycleLimit = 600000;
    localparam int unsigned DrainCycles = 120;

    class compensation_scoreboard;
        bit [63:0] coef [5];
        esc_out_t pending [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned invalid_seen;
        int unsigned clamp_seen;

        function new();
            foreach (coef[i]) coef[i] = '0;
            errors = 0;
            checked = 0;
            invalid_seen = 0;
            clamp_seen = 0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, bit [63:0] val);
            case (idx)
                REG_TEMP:      coef[0] = val & 64'hFFFF_FFFF_FFFF;
                REG_PRESS_LOW: coef[1] = val;
                REG_PRESS_HI:  coef[2] = val;
                REG_MIXED:     coef[3] = val & 64'hFF_FFFF_FFFF;
                REG_HUM:       coef[4] = val & 64'hFFFF_FFFF_FFFF;
                default: ;
            endcase
        endfunction

        function bit [31:0] sra32(bit [31:0] v, int unsigned n);
            return $signed(v) >>> n;
        endfunction

        function bit [63:0] sra64(bit [63:0] v, int unsigned n);
            return $signed(v) >>> n;
        endfunction

        function bit [31:0] sx32(bit [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        function bit [63:0] sx64(bit [15:0] v);
            return {{48{v[15]}}, v};
        endfunction

        function esc_out_t compensate(esc_in_t s);
            bit [31:0] adc_t, adc_h, t1, t2, t3, a, b, v1, v2, tf;
            bit [31:0] h1, h2, h3, h4, h5, h6, x, y, lft, in1, in2, rgt;
            bit [63:0] adc_p, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            bit [63:0] w1, w2, p, p13, num, an, ad, q;
            esc_out_t r;
            adc_t = {12'b0, s.raw_temperature};
            adc_p = {44'b0, s.raw_pressure};
            adc_h = {16'b0, s.raw_humidity};

            t1 = {16'b0, coef[0][15:0]};
            t2 = sx32(coef[0][31:16]);
            t3 = sx32(coef[0][47:32]);
            a = (adc_t >> 3) - (t1 << 1);
            v1 = sra32(a * t2, 11);
            b = (adc_t >> 4) - t1;
            v2 = sra32(sra32(b * b, 12) * t3, 14);
            tf = v1 + v2;

            p1 = {48'b0, coef[1][15:0]};
            p2 = sx64(coef[1][31:16]);
            p3 = sx64(coef[1][47:32]);
            p4 = sx64(coef[1][63:48]);
            p5 = sx64(coef[2][15:0]);
            p6 = sx64(coef[2][31:16]);
            p7 = sx64(coef[2][47:32]);
            p8 = sx64(coef[2][63:48]);
            p9 = sx64(coef[3][15:0]);
            w1 = {{32{tf[31]}}, tf} - 64'd128000;
            w2 = w1 * w1 * p6;
            w2 = w2 + ((w1 * p5) << 17);
            w2 = w2 + (p4 << 35);
            w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
            w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
            r.pressure_q24_8 = '0;
            r.pressure_valid = 1'b0;
            if (w1 != 0) begin
                p = 64'd1048576 - adc_p;
                num = ((p << 31) - w2) * 64'd3125;
                // signed divide, truncating toward zero
                an = num[63] ? -num : num;
                ad = w1[63] ? -w1 : w1;
                q = an / ad;
                p = (num[63] != w1[63]) ? -q : q;
                p13 = sra64(p, 13);
                w1 = sra64(p9 * p13 * p13, 25);
                w2 = sra64(p8 * p, 19);
                p = sra64(p + w1 + w2, 8) + (p7 << 4);
                r.pressure_q24_8 = p[31:0];
                r.pressure_valid = 1'b1;
            end

            h1 = {24'b0, coef[3][23:16]};
            h3 = {24'b0, coef[3][31:24]};
            h6 = {{24{coef[3][39]}}, coef[3][39:32]};
            h2 = sx32(coef[4][15:0]);
            h4 = sx32(coef[4][31:16]);
            h5 = sx32(coef[4][47:32]);
            x = tf - 32'd76800;
            lft = sra32((adc_h << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
            in1 = sra32(x * h6, 10);
            in2 = sra32(x * h3, 11) + 32'd32768;
            rgt = sra32(in1 * in2, 10) + 32'd2097152;
            rgt = sra32(rgt * h2 + 32'd8192, 14);
            x = lft * rgt;
            y = sra32(x, 15);
            x = x - sra32(sra32(y * y, 7) * h1, 4);
            if (x[31]) begin
                x = 0;
            end else if (x > 32'd419430400) begin
                x = 32'd419430400;
            end
            r.humidity_q22_10 = x[28:12];
            r.fine_temperature = tf;
            return r;
        endfunction

        function void note_input(esc_in_t s);
            pending.push_back(compensate(s));
        endfunction

        task report(string what, bit [63:0] got, bit [63:0] want);
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(esc_out_t got);
            esc_out_t want;
            if (pending.size() == 0) begin
                report("unexpected result", {32'd0, got.pressure_q24_8}, 64'd0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (!want.pressure_valid) invalid_seen++;
            if (want.humidity_q22_10 == 0 || want.humidity_q22_10 == 17'd102400) clamp_seen++;
            if (got.fine_temperature !== want.fine_temperature)
                report("fine_temperature", {32'd0, got.fine_temperature},
                       {32'd0, want.fine_temperature});
            if (got.pressure_q24_8 !== want.pressure_q24_8)
                report("pressure_q24_8", {32'd0, got.pressure_q24_8},
                       {32'd0, want.pressure_q24_8});
            if (got.pressure_valid !== want.pressure_valid)
                report("pressure_valid", {63'd0, got.pressure_valid},
                       {63'd0, want.pressure_valid});
            if (got.humidity_q22_10 !== want.humidity_q22_10)
                report("humidity_q22_10", {47'd0, got.humidity_q22_10},
                       {47'd0, want.humidity_q22_10});
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    esc_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    esc_out_t m_data;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;

    compensation_scoreboard sb = new();
    int unsigned cycles = 0;
    int unsigned snd_idle = 0;
    int unsigned rcv_idle = 0;
    bit hold_req = 0;
    int unsigned hold_left = 0;
    int unsigned sent = 0;

    env_sensor_compensation dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // note each transfer on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    task send_item(esc_in_t item);
        while ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task write_reg(logic [CfgIdxW-1:0] idx, bit [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // let the clock advance first so the last transfer is already noted
    task wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function esc_in_t random_item();
        esc_in_t it;
        it.raw_temperature = 20'($urandom);
        it.raw_pressure = 20'($urandom);
        it.raw_humidity = 16'($urandom);
        // near typical readings part of the time
        if ($urandom_range(9) < 3) begin
            it.raw_temperature = 20'(519888 + $urandom_range(80000) - 40000);
            it.raw_pressure = 20'(415148 + $urandom_range(80000) - 40000);
            it.raw_humidity = 16'(30000 + $urandom_range(20000) - 10000);
        end
        return it;
    endfunction

    task load_coeffs(int ph);
        bit [63:0] v [5];
        case (ph)
            1: begin
                v[0] = 64'({16'hFC18, 16'd26435, 16'd27504});
                v[1] = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
                v[2] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
                v[3] = 64'({8'd30, 8'd0, 8'd75, 16'd6000});
                v[4] = 64'({16'd50, 16'd313, 16'd362});
            end
            2: foreach (v[i]) v[i] = '1;
            3: begin
                // zero scale coefficient: pressure divisor is zero
                v[0] = 64'({16'hFC18, 16'd26435, 16'd27504});
                v[1] = {16'd2855, 16'd3024, 16'hD643, 16'd0};
                v[2] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
                v[3] = 64'({8'd30, 8'd0, 8'd75, 16'd6000});
                v[4] = 64'({16'd50, 16'd313, 16'd362});
            end
            4: begin
                v[0] = 64'({16'h7FFF, 16'h7FFF, 16'hFFFF});
                v[1] = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
                v[2] = {4{16'h7FFF}};
                v[3] = 64'({8'h7F, 8'hFF, 8'hFF, 16'h7FFF});
                v[4] = 64'({3{16'h7FFF}});
            end
            5: begin
                v[0] = 64'({16'h8000, 16'h8000, 16'h0000});
                v[1] = {16'h8000, 16'h8000, 16'h8000, 16'h0001};
                v[2] = {4{16'h8000}};
                v[3] = 64'({8'h80, 8'h00, 8'h00, 16'h8000});
                v[4] = 64'({3{16'h8000}});
            end
            default: foreach (v[i]) v[i] = {$urandom, $urandom};
        endcase
        for (int i = 0; i < 5; i++) write_reg(CfgIdxW'(i), v[i]);
        // unused indexes must leave the registers alone
        if (ph == 6) begin
            write_reg(3'd5, {$urandom, $urandom});
            write_reg(3'd7, '1);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task run_directed();
        esc_in_t it;
        bit [19:0] tv [4] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'd519888};
        bit [19:0] pv [4] = '{20'h00000, 20'hFFFFF, 20'd415148, 20'h7FFFF};
        bit [15:0] hv [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'd30000};
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                it.raw_temperature = tv[i];
                it.raw_pressure = pv[j];
                it.raw_humidity = hv[(i + j) % 4];
                send_item(it);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < 10; ph++) begin
            if (ph > 0) begin
                wait_drained();
                repeat (DrainCycles) @(posedge aclk);
                load_coeffs(ph);
            end
            case (ph % 4)
                0: begin snd_idle = 0;  rcv_idle = 0;  end
                1: begin snd_idle = 58; rcv_idle = 0;  end
                2: begin snd_idle = 0;  rcv_idle = 58; end
                default: begin snd_idle = 21; rcv_idle = 21; end
            endcase
            if (ph == 1) run_directed();
            for (int k = 0; k < 105; k++) begin
                if (ph == 2 && k == 20) hold_req = 1;
                if (ph == 5 && k == 50) wait_drained();
                send_item(random_item());
            end
        end
        wait_drained();
        repeat (DrainCycles) @(posedge aclk);
        $display("Covered %0d samples over 10 coefficient sets, %0d results checked",
                 sent, sb.checked);
        $display("Zero-divisor results %0d, clamped humidity results %0d",
                 sb.invalid_seen, sb.clamp_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/esc_pkg.sv
sv/esc_sdiv.sv
sv/env_sensor_compensation.sv
sim/testbench.sv
